// ----- sv/chr_pkg.sv -----
// Shared types and codes for the consistent hash ring lookup core.
// No dependencies; used by chr_cell and consistent_hash_ring_lookup_core.
package chr_pkg;

    localparam int POS_W   = 64;
    localparam int NODE_W  = 6;
    localparam int CNT_RC_W = 4;

    typedef enum logic [1:0] {
        KIND_INSERT = 2'd0,
        KIND_REMOVE = 2'd1,
        KIND_CLEAR  = 2'd2,
        KIND_LOOKUP = 2'd3
    } chr_kind_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_COLLISION = 2'd1,
        ST_ABSENT    = 2'd2,
        ST_FULL      = 2'd3
    } chr_status_t;

    typedef enum logic [2:0] {
        CMD_HOLD,
        CMD_INS,
        CMD_DEL,
        CMD_OWN,
        CMD_CLR,
        CMD_TOK_LOAD,
        CMD_TOK_STEP
    } chr_cmd_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLR,
        S_CHK,
        S_APPLY,
        S_LOOK,
        S_WALK,
        S_EMIT
    } chr_state_t;

    typedef struct packed {
        logic [1:0]        kind;
        logic [POS_W-1:0]  position;
        logic [NODE_W-1:0] node;
    } chr_in_t;

    typedef struct packed {
        logic [NODE_W-1:0] owner;
        logic              owner_valid;
        logic [1:0]        status;
        logic              replica_short;
        logic              last;
    } chr_out_t;

    typedef struct packed {
        logic              valid;
        logic [POS_W-1:0]  pos;
        logic [NODE_W-1:0] owner;
    } chr_entry_t;

    typedef struct packed {
        chr_cmd_t          cmd;
        logic [POS_W-1:0]  key;
        logic [NODE_W-1:0] node;
    } chr_cell_ctl_t;

endpackage

// ----- sv/chr_cell.sv -----
// One ring slot: holds a position, its owner and a walk token.
// Depends on chr_pkg.
module chr_cell
    import chr_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  chr_cell_ctl_t ctl,
    input  chr_entry_t    left,
    input  chr_entry_t    right,
    input  logic          lt_left,
    input  logic          tok_in,
    input  logic          tok_load,
    output chr_entry_t    ent,
    output logic          lt,
    output logic          eq,
    output logic          tok
);

    logic              valid_reg, valid_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [NODE_W-1:0] owner_reg, owner_next;
    logic              tok_reg, tok_next;

    assign lt  = valid_reg && (pos_reg < ctl.key);
    assign eq  = valid_reg && (pos_reg == ctl.key);
    assign tok = tok_reg;
    assign ent = '{valid: valid_reg, pos: pos_reg, owner: owner_reg};

    always_comb
    begin
        valid_next = valid_reg;
        pos_next   = pos_reg;
        owner_next = owner_reg;
        tok_next   = tok_reg;
        case (ctl.cmd)
            CMD_INS:
            begin
                if (!lt)
                begin
                    if (lt_left)
                    begin
                        valid_next = 1'b1;
                        pos_next   = ctl.key;
                        owner_next = ctl.node;
                    end
                    else
                    begin
                        valid_next = left.valid;
                        pos_next   = left.pos;
                        owner_next = left.owner;
                    end
                end
            end
            CMD_DEL:
            begin
                // slots from the removed one upward pull from the right
                if (!lt)
                begin
                    valid_next = right.valid;
                    pos_next   = right.pos;
                    owner_next = right.owner;
                end
            end
            CMD_OWN:
            begin
                if (eq)
                    owner_next = ctl.node;
            end
            CMD_CLR:      valid_next = 1'b0;
            CMD_TOK_LOAD: tok_next = tok_load;
            CMD_TOK_STEP: tok_next = tok_in && valid_reg;
            default:      ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            tok_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            tok_reg   <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg   <= pos_next;
        owner_reg <= owner_next;
    end

endmodule

// ----- sv/consistent_hash_ring_lookup_core.sv -----
// Consistent hash ring: sorted row of slot cells plus a command sequencer.
// Depends on chr_pkg and chr_cell.
// Clear and insert/remove answer with one word; a lookup walks the token through
// the ring, one slot per cycle, then sends one word per distinct owner found; on
// an empty ring or with count zero it sends one empty word. One word in flight;
// busy drops as done strobes the last word; no stall. Reset: ring empty, count 3.
module consistent_hash_ring_lookup_core
    import chr_pkg::*;
#(
    parameter int RING_ENTRIES = 256,
    parameter int MAX_NODES    = 64,
    parameter int MAX_REPLICAS = 8
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  chr_in_t             request,
    output logic                busy,
    output logic                done,
    output chr_out_t            result,
    input  logic                cfg_we,
    input  logic [CNT_RC_W-1:0] cfg_data
);

    localparam int CW  = $clog2(RING_ENTRIES + 1);
    localparam int NFW = $clog2(MAX_REPLICAS + 1);

    chr_state_t          state_reg, state_next;
    logic [CNT_RC_W-1:0] rc_reg;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic [CW-1:0]       step_reg, step_next;
    logic [NFW-1:0]      nf_reg, nf_next;
    logic [NFW-1:0]      want;
    logic [1:0]          kind_reg;
    logic [POS_W-1:0]    key_reg;
    logic [NODE_W-1:0]   node_reg;
    chr_cmd_t            act_reg, act_next;
    logic [1:0]          st_reg, st_next;
    logic [NODE_W-1:0]   found_reg [MAX_REPLICAS];
    logic [NODE_W-1:0]   found_next [MAX_REPLICAS];
    chr_out_t            res_reg, res_next;
    logic                done_reg, done_next;

    chr_cell_ctl_t       ctl;
    chr_entry_t          ent [RING_ENTRIES];
    logic [RING_ENTRIES-1:0] lt_v, eq_v, tok_v, valid_v, ltl_v, start_v;
    logic                nostart, wrap, hit, seen;
    logic [NODE_W-1:0]   hit_owner, rd_owner;

    // slot row
    for (genvar j = 0; j < RING_ENTRIES; j++)
    begin : g_cell
        chr_entry_t lft, rgt;
        logic       tin, tld;
        if (j == 0)
        begin : g_first
            assign lft      = '0;
            assign tin      = wrap;
            assign tld      = start_v[0] | nostart;
            assign ltl_v[0] = 1'b1;
        end
        else
        begin : g_mid
            assign lft      = ent[j-1];
            assign tin      = tok_v[j-1];
            assign tld      = start_v[j];
            assign ltl_v[j] = lt_v[j-1];
        end
        if (j == RING_ENTRIES - 1)
        begin : g_end
            assign rgt = '0;
        end
        else
        begin : g_inner
            assign rgt = ent[j+1];
        end
        chr_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl      (ctl),
            .left     (lft),
            .right    (rgt),
            .lt_left  (ltl_v[j]),
            .tok_in   (tin),
            .tok_load (tld),
            .ent      (ent[j]),
            .lt       (lt_v[j]),
            .eq       (eq_v[j]),
            .tok      (tok_v[j])
        );
        assign valid_v[j] = ent[j].valid;
        assign start_v[j] = valid_v[j] && !lt_v[j] && ltl_v[j];
    end

    assign nostart = ~|start_v;

    always_comb
    begin
        hit_owner = '0;
        rd_owner  = '0;
        wrap      = 1'b0;
        for (int j = 0; j < RING_ENTRIES; j++)
        begin
            if (eq_v[j])
                hit_owner = hit_owner | ent[j].owner;
            if (tok_v[j])
                rd_owner = rd_owner | ent[j].owner;
            if (tok_v[j] && (j == RING_ENTRIES - 1 || !valid_v[(j + 1) % RING_ENTRIES]))
                wrap = 1'b1;
        end
    end

    assign hit  = |eq_v;
    assign want = (32'(rc_reg) > MAX_REPLICAS) ? NFW'(MAX_REPLICAS) : NFW'(rc_reg);

    always_comb
    begin
        seen = 1'b0;
        for (int m = 0; m < MAX_REPLICAS; m++)
            if (NFW'(m) < nf_reg && found_reg[m] == rd_owner)
                seen = 1'b1;
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        step_next  = step_reg;
        nf_next    = nf_reg;
        act_next   = act_reg;
        st_next    = st_reg;
        found_next = found_reg;
        res_next   = res_reg;
        done_next  = 1'b0;
        ctl.cmd    = CMD_HOLD;
        ctl.key    = key_reg;
        ctl.node   = node_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    case (request.kind)
                        KIND_CLEAR:  state_next = S_CLR;
                        KIND_LOOKUP: state_next = S_LOOK;
                        default:     state_next = S_CHK;
                    endcase
                end
            end
            S_CLR:
            begin
                ctl.cmd    = CMD_CLR;
                cnt_next   = '0;
                res_next   = '{owner: '0, owner_valid: 1'b0, status: ST_OK,
                               replica_short: 1'b0, last: 1'b1};
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            S_CHK:
            begin
                act_next   = CMD_HOLD;
                st_next    = ST_OK;
                if (kind_reg == KIND_INSERT)
                begin
                    if (32'(node_reg) >= MAX_NODES)
                        st_next = ST_ABSENT;
                    else if (hit)
                    begin
                        if (hit_owner <= node_reg)
                            st_next = ST_COLLISION;
                        else
                            act_next = CMD_OWN;
                    end
                    else if (valid_v[RING_ENTRIES-1])
                        st_next = ST_FULL;
                    else
                        act_next = CMD_INS;
                end
                else
                begin
                    if (hit && hit_owner == node_reg)
                        act_next = CMD_DEL;
                    else
                        st_next = ST_ABSENT;
                end
                state_next = S_APPLY;
            end
            S_APPLY:
            begin
                ctl.cmd = act_reg;
                if (act_reg == CMD_INS)
                    cnt_next = cnt_reg + 1'b1;
                else if (act_reg == CMD_DEL)
                    cnt_next = cnt_reg - 1'b1;
                res_next   = '{owner: '0, owner_valid: 1'b0, status: st_reg,
                               replica_short: 1'b0, last: 1'b1};
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            S_LOOK:
            begin
                step_next = '0;
                nf_next   = '0;
                if (want == '0 || cnt_reg == '0)
                begin
                    res_next   = '{owner: '0, owner_valid: 1'b0, status: ST_OK,
                                   replica_short: (want != '0), last: 1'b1};
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    ctl.cmd    = CMD_TOK_LOAD;
                    state_next = S_WALK;
                end
            end
            S_WALK:
            begin
                ctl.cmd   = CMD_TOK_STEP;
                step_next = step_reg + 1'b1;
                if (!seen)
                begin
                    for (int m = 0; m < MAX_REPLICAS; m++)
                        if (NFW'(m) == nf_reg)
                            found_next[m] = rd_owner;
                    nf_next = nf_reg + 1'b1;
                end
                if (step_next == cnt_reg || nf_next == want)
                    state_next = S_EMIT;
            end
            S_EMIT:
            begin
                // emit from the head of the found list, then shift it down
                res_next = '{owner: found_reg[0], owner_valid: 1'b1, status: ST_OK,
                             replica_short: (nf_reg < want),
                             last: (step_reg == CW'(1))};
                done_next = 1'b1;
                for (int m = 0; m < MAX_REPLICAS - 1; m++)
                    found_next[m] = found_reg[m+1];
                step_next = step_reg - 1'b1;
                if (step_reg == CW'(1))
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
        // on entry to emit, step counts results still to send
        if (state_reg == S_WALK && state_next == S_EMIT)
            step_next = CW'(nf_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            rc_reg    <= CNT_RC_W'(3);
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
            if (cfg_we)
                rc_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg  <= step_next;
        nf_reg    <= nf_next;
        act_reg   <= act_next;
        st_reg    <= st_next;
        found_reg <= found_next;
        res_reg   <= res_next;
        if (state_reg == S_IDLE && start)
        begin
            kind_reg <= request.kind;
            key_reg  <= request.position;
            node_reg <= request.node;
        end
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = res_reg;

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(cnt_reg) <= RING_ENTRIES)
        else $error("entry count above ring size");
    a_tok_single: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(tok_v))
        else $error("more than one walk token");
    a_owner_ok: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.owner_valid |-> result.status == ST_OK)
        else $error("replica word with nonzero status");
    a_no_owner_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && !result.owner_valid |-> result.owner == '0 && result.last)
        else $error("empty word carries owner or is not last");

endmodule
